[hdl/pse_pkg.sv]
// Shared types and constants of the postfix stack evaluator.
package pse_pkg;

	// ASCII codes of the accepted symbols
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;

	// result status codes
	localparam logic [2:0] STAT_OK    = 3'd0;
	localparam logic [2:0] STAT_UNDER = 3'd1;
	localparam logic [2:0] STAT_OVER  = 3'd2;
	localparam logic [2:0] STAT_DIVZ  = 3'd3;
	localparam logic [2:0] STAT_BAD   = 3'd4;

	// data width of a stack entry and quotient step count
	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EXEC   = 5'b00010,
		S_DIV    = 5'b00100,
		S_DFIX   = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	// input item
	typedef struct packed {
		logic [7:0] symbol;
		logic       last_symbol;
	} sym_t;

	// result item
	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         status;
	} res_t;

endpackage

[hdl/pse_stream_if.sv]
// Valid/ready stream interface that carries one item per handshake.
interface pse_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hdl/postfix_stack_evaluator.sv]
// Postfix expression evaluator: operand stack, shared add/subtract unit, serial divider.
//
// Takes one ASCII symbol per item; the item with last_symbol set closes the
// expression and yields one result (value, status), after which the stack and
// the latched error are cleared. A digit is handled in S_IDLE alone; + - *
// read the second stack entry into a register, then execute in S_EXEC; a /
// does setup in S_EXEC, 32 restoring quotient steps through the shared
// subtractor in S_DIV and the sign fix in S_DFIX. S_FINISH loads the output
// register, which holds the result while the block goes on taking items; the
// next last symbol waits there if that result has not been taken yet. The top
// of stack lives in a register, the entries below it in a memory of
// STACK_DEPTH words that needs no clearing after reset. Errors: underflow on
// too few operands or an empty stack at the end, overflow when a digit finds
// the stack full, divide by zero, bad symbol; the first one is latched and
// reported with value 0.
module postfix_stack_evaluator #(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	pse_stream_if.sink   symbols,
	pse_stream_if.source results
);
	import pse_pkg::*;

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [CW-1:0] TWO_C   = CW'(2);

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [2:0]      err_q;
	logic            last_q;
	op_t             op_q;
	logic [4:0]      step_q;
	logic            qneg_q;
	logic            out_valid_q;
	res_t            res_q;

	logic [DATA_W-1:0] tos_q;
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] mb_q;
	logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

	sym_t   in_item;
	logic   accept;
	logic   is_digit;
	logic   is_op;
	op_t    dec_op;
	logic   push_we;
	logic   rd_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] count_m1;
	logic [CW-1:0] count_m2;
	logic   out_free;

	logic [DATA_W:0]     alu_x;
	logic [DATA_W:0]     alu_y;
	logic                alu_sub;
	logic [DATA_W:0]     alu_r;
	logic [DATA_W:0]     rem_sh;
	logic [DATA_W-1:0]   mul_p;
	logic [DATA_W-1:0]   mag_a;
	logic [DATA_W-1:0]   mag_b;

	assign in_item = symbols.payload;
	assign symbols.ready = (state_q == S_IDLE);
	assign accept = symbols.valid && symbols.ready;
	assign results.valid = out_valid_q;
	assign results.payload = res_q;
	assign out_free = !out_valid_q || results.ready;

	// symbol decode
	always_comb begin
		is_digit = (in_item.symbol >= CH_0) && (in_item.symbol <= CH_9);
		is_op = 1'b1;
		dec_op = OP_ADD;
		case (in_item.symbol)
			CH_PLUS:  dec_op = OP_ADD;
			CH_MINUS: dec_op = OP_SUB;
			CH_MUL:   dec_op = OP_MUL;
			CH_DIV:   dec_op = OP_DIV;
			default:  is_op = 1'b0;
		endcase
	end

	// stack addresses: entry count-1 takes the old top on a push,
	// entry count-2 is the second operand
	assign count_m1 = count_q - ONE_C;
	assign count_m2 = count_q - TWO_C;
	assign wr_addr = count_m1[AW-1:0];
	assign rd_addr = count_m2[AW-1:0];
	assign push_we = accept && (err_q == STAT_OK) && is_digit
		&& (count_q != DEPTH_C) && (count_q != '0);
	assign rd_en = accept && (err_q == STAT_OK) && is_op && (count_q >= TWO_C);

	// shared add/subtract unit
	assign rem_sh = {rem_q, quo_q[DATA_W-1]};
	always_comb begin
		alu_x = {1'b0, rd_q};
		alu_y = {1'b0, tos_q};
		alu_sub = (op_q == OP_SUB);
		case (state_q)
			S_DIV: begin
				alu_x = rem_sh;
				alu_y = {1'b0, mb_q};
				alu_sub = 1'b1;
			end
			S_DFIX: begin
				alu_x = '0;
				alu_y = {1'b0, quo_q};
				alu_sub = 1'b1;
			end
			default: ;
		endcase
		alu_r = alu_sub ? (alu_x + ~alu_y + (DATA_W+1)'(1)) : (alu_x + alu_y);
	end

	assign mul_p = rd_q * tos_q;
	assign mag_a = rd_q[DATA_W-1] ? (~rd_q + DATA_W'(1)) : rd_q;
	assign mag_b = tos_q[DATA_W-1] ? (~tos_q + DATA_W'(1)) : tos_q;

	// operand memory
	always_ff @(posedge clk) begin
		if (push_we)
			stack_mem[wr_addr] <= tos_q;
		if (rd_en)
			rd_q <= stack_mem[rd_addr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (push_we || (accept && (err_q == STAT_OK) && is_digit
					&& (count_q == '0)))
					tos_q <= {{(DATA_W-4){1'b0}}, in_item.symbol[3:0]};
			end
			S_EXEC: begin
				case (op_q)
					OP_ADD, OP_SUB: tos_q <= alu_r[DATA_W-1:0];
					OP_MUL:         tos_q <= mul_p;
					default: begin
						quo_q <= mag_a;
						rem_q <= '0;
						mb_q <= mag_b;
					end
				endcase
			end
			S_DIV: begin
				if (!alu_r[DATA_W]) begin
					rem_q <= alu_r[DATA_W-1:0];
					quo_q <= {quo_q[DATA_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[DATA_W-1:0];
					quo_q <= {quo_q[DATA_W-2:0], 1'b0};
				end
			end
			S_DFIX: begin
				tos_q <= qneg_q ? alu_r[DATA_W-1:0] : quo_q;
			end
			S_FINISH: begin
				if (out_free) begin
					if (err_q != STAT_OK) begin
						res_q.value <= '0;
						res_q.status <= err_q;
					end else if (count_q == '0) begin
						res_q.value <= '0;
						res_q.status <= STAT_UNDER;
					end else begin
						res_q.value <= tos_q;
						res_q.status <= STAT_OK;
					end
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			err_q <= STAT_OK;
			last_q <= 1'b0;
			op_q <= OP_ADD;
			step_q <= '0;
			qneg_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: loaded at the end of an expression, freed when taken
			if ((state_q == S_FINISH) && out_free)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= in_item.last_symbol;
						op_q <= dec_op;
						if ((err_q == STAT_OK) && is_op && (count_q >= TWO_C))
							state_q <= S_EXEC;
						else if (in_item.last_symbol)
							state_q <= S_FINISH;
						if (err_q == STAT_OK) begin
							if (is_digit) begin
								if (count_q == DEPTH_C)
									err_q <= STAT_OVER;
								else
									count_q <= count_q + ONE_C;
							end else if (is_op) begin
								if (count_q < TWO_C)
									err_q <= STAT_UNDER;
							end else begin
								err_q <= STAT_BAD;
							end
						end
					end
				end
				S_EXEC: begin
					if (op_q == OP_DIV) begin
						if (tos_q == '0) begin
							err_q <= STAT_DIVZ;
							state_q <= last_q ? S_FINISH : S_IDLE;
						end else begin
							qneg_q <= rd_q[DATA_W-1] ^ tos_q[DATA_W-1];
							step_q <= '0;
							state_q <= S_DIV;
						end
					end else begin
						count_q <= count_m1;
						state_q <= last_q ? S_FINISH : S_IDLE;
					end
				end
				S_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd31)
						state_q <= S_DFIX;
				end
				S_DFIX: begin
					count_q <= count_m1;
					state_q <= last_q ? S_FINISH : S_IDLE;
				end
				S_FINISH: begin
					if (out_free) begin
						count_q <= '0;
						err_q <= STAT_OK;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// stack never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("stack count above depth");

	// the divider never runs on a zero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (mb_q != '0))
		else $error("divider started with zero divisor");

	// a finished expression leaves a result and an empty stack
	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FINISH) && out_free) |=>
		(out_valid_q && (count_q == '0) && (err_q == STAT_OK)))
		else $error("expression end did not load result or clear stack");

	// an operator is only executed with two operands held
	a_exec_operands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> (count_q >= TWO_C))
		else $error("operator executed with fewer than two operands");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench of the postfix stack evaluator: directed table, then random expressions.
`timescale 1ns / 100ps

module tb_top;
	import pse_pkg::*;

	localparam int DEPTH        = 64;
	localparam int ITEMS        = 1700;
	localparam int NUM_DIRECTED = 25;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 600;
	localparam int QUIET_FROM   = 900;
	localparam int QUIET_TO     = 1200;
	localparam int IDLE_PCT     = 11;
	localparam int SHOW_MAX     = 10;

	// symbols outside the accepted set
	localparam logic [7:0] SYM_NUL   = 8'h00;
	localparam logic [7:0] SYM_ALL1  = 8'hFF;
	localparam logic [7:0] SYM_COLON = 8'h3A;

	typedef enum int {
		EXPR_CLEAN,
		EXPR_BROKEN,
		EXPR_NOISE,
		EXPR_FILL,
		EXPR_MINDIV,
		EXPR_SINGLE,
		EXPR_KINDS
	} expr_kind_e;

	// one symbol to send; preset marks a result written into the table by hand
	typedef struct packed {
		logic [7:0]         symbol;
		logic               last;
		logic               preset;
		logic signed [31:0] value;
		logic [2:0]         status;
	} stim_t;

	logic clk;
	logic arst_n;

	pse_stream_if #(.payload_t(sym_t)) sym_ch ();
	pse_stream_if #(.payload_t(res_t)) res_ch ();

	postfix_stack_evaluator #(.STACK_DEPTH(DEPTH)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.symbols (sym_ch),
		.results (res_ch)
	);

	// predictor state
	logic [31:0] stack_words [DEPTH];
	int unsigned stack_fill;
	logic [2:0]  stack_err;

	stim_t      symbol_stream [$];
	logic [7:0] expr_syms [$];
	res_t       pending_results [$];
	stim_t      offered;
	bit         quiet;
	int         accepted_items;
	int         results_seen;
	int         mismatches;
	int         stall_cycles;
	int         expr_total;
	int         status_count [5];

	// directed expressions; the last row of each carries the end mark
	stim_t directed_rows [NUM_DIRECTED] = '{
		'{CH_0 + 8'd9, 1'b1, 1'b1, 32'sd9, STAT_OK},
		'{CH_0,        1'b1, 1'b1, 32'sd0, STAT_OK},
		'{CH_PLUS,     1'b1, 1'b1, 32'sd0, STAT_UNDER},
		'{CH_0 + 8'd5, 1'b0, 1'b0, 32'sd0, STAT_OK},
		'{CH_0 + 8'd3, 1'b0, 1'b0, 32'sd0, STAT_OK},
		'{CH_MINUS,    1'b1, 1'b0, 32'sd0, STAT_OK},
		'{CH_0 + 8'd6, 1'b0, 1'b0, 32'sd0, STAT_OK},
		'{CH_0 + 8'd7, 1'b0, 1'b0, 32'sd0, STAT_OK},
		'{CH_MUL,      1'b1, 1'b0, 32'sd0, STAT_OK},
		'{CH_0 + 8'd3, 1'b0, 1'b0, 32'sd0, STAT_OK},
		'{CH_0 + 8'd7, 1'b0, 1'b0, 32'sd0, STAT_OK},
		'{CH_MINUS,    1'b0, 1'b0, 32'sd0, STAT_OK},
		'{CH_0 + 8'd3, 1'b0, 1'b0, 32'sd0, STAT_OK},
		'{CH_DIV,      1'b1, 1'b0, 32'sd0, STAT_OK},
		'{CH_0 + 8'd8, 1'b0, 1'b0, 32'sd0, STAT_OK},
		'{CH_0,        1'b0, 1'b0, 32'sd0, STAT_OK},
		'{CH_DIV,      1'b1, 1'b1, 32'sd0, STAT_DIVZ},
		'{SYM_NUL,     1'b1, 1'b1, 32'sd0, STAT_BAD},
		'{SYM_ALL1,    1'b1, 1'b1, 32'sd0, STAT_BAD},
		'{CH_0 + 8'd1, 1'b0, 1'b0, 32'sd0, STAT_OK},
		'{SYM_COLON,   1'b0, 1'b0, 32'sd0, STAT_OK},
		'{CH_DIV,      1'b0, 1'b0, 32'sd0, STAT_OK},
		'{CH_0 + 8'd9, 1'b1, 1'b1, 32'sd0, STAT_BAD},
		'{CH_0 + 8'd1, 1'b0, 1'b0, 32'sd0, STAT_OK},
		'{CH_0 + 8'd2, 1'b1, 1'b0, 32'sd0, STAT_OK}
	};

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// evaluates one symbol; returns 1 with the result when the expression ends
	function automatic bit evaluate_symbol(input sym_t it, output res_t r);
		logic [31:0] a, b, mag_a, mag_b, q;
		op_t op;
		r  = '0;
		op = OP_ADD;
		q  = '0;
		if (stack_err == STAT_OK) begin
			if (it.symbol >= CH_0 && it.symbol <= CH_9) begin
				if (stack_fill >= DEPTH)
					stack_err = STAT_OVER;
				else begin
					stack_words[stack_fill] = 32'(it.symbol - CH_0);
					stack_fill++;
				end
			end else begin
				case (it.symbol)
					CH_PLUS:  op = OP_ADD;
					CH_MINUS: op = OP_SUB;
					CH_MUL:   op = OP_MUL;
					CH_DIV:   op = OP_DIV;
					default:  stack_err = STAT_BAD;
				endcase
				if (stack_err == STAT_OK) begin
					if (stack_fill < 2)
						stack_err = STAT_UNDER;
					else begin
						b = stack_words[stack_fill - 1];
						a = stack_words[stack_fill - 2];
						case (op)
							OP_ADD: q = a + b;
							OP_SUB: q = a - b;
							OP_MUL: q = a * b;
							default: begin
								// divide magnitudes, then restore the sign; rounds toward zero
								mag_a = a[31] ? -a : a;
								mag_b = b[31] ? -b : b;
								if (b != 0)
									q = mag_a / mag_b;
								if (a[31] != b[31])
									q = -q;
							end
						endcase
						if (op == OP_DIV && b == 0)
							stack_err = STAT_DIVZ;
						else begin
							stack_words[stack_fill - 2] = q;
							stack_fill--;
						end
					end
				end
			end
		end
		if (!it.last_symbol)
			return 1'b0;
		r.status = stack_err;
		if (stack_err == STAT_OK) begin
			if (stack_fill == 0)
				r.status = STAT_UNDER;
			else
				r.value = stack_words[stack_fill - 1];
		end
		stack_fill = 0;
		stack_err  = STAT_OK;
		return 1'b1;
	endfunction

	function automatic logic [7:0] random_digit();
		return CH_0 + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] random_op();
		case ($urandom_range(3))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_MUL;
			default: return CH_DIV;
		endcase
	endfunction

	// well-formed expression with random digits and operators
	task automatic build_clean();
		int len;
		int depth;
		len   = ($urandom_range(9) == 0) ? $urandom_range(45, 15) : $urandom_range(12, 1);
		depth = 0;
		expr_syms.delete();
		repeat (len) begin
			if (depth < 2 || (depth < DEPTH && $urandom_range(99) < 45)) begin
				expr_syms.push_back(random_digit());
				depth++;
			end else begin
				expr_syms.push_back(random_op());
				depth--;
			end
		end
		// mostly reduce to a single value, sometimes leave several entries
		if ($urandom_range(3) != 0) begin
			while (depth > 1) begin
				expr_syms.push_back(random_op());
				depth--;
			end
		end
	endtask

	// builds one expression of the given kind and appends it to the stream
	task automatic add_random_expression(input expr_kind_e kind);
		int n;
		int pos;
		stim_t e;
		expr_syms.delete();
		case (kind)
			EXPR_CLEAN: build_clean();
			EXPR_BROKEN: begin
				build_clean();
				pos = $urandom_range(expr_syms.size() - 1);
				if ($urandom_range(1))
					expr_syms.insert(pos, 8'($urandom_range(255)));
				else
					expr_syms.insert(0, random_op());
			end
			EXPR_NOISE: begin
				repeat ($urandom_range(6, 1))
					expr_syms.push_back(8'($urandom_range(255)));
			end
			EXPR_FILL: begin
				// around the stack depth, past it now and then
				n = $urandom_range(68, 60);
				repeat (n)
					expr_syms.push_back(random_digit());
				repeat ($urandom_range(((n > DEPTH) ? DEPTH : n) - 1))
					expr_syms.push_back(random_op());
			end
			EXPR_MINDIV: begin
				// 8^10 * 2 wraps to the most negative value, then divide by -1
				expr_syms.push_back(CH_0 + 8'd8);
				repeat (9) begin
					expr_syms.push_back(CH_0 + 8'd8);
					expr_syms.push_back(CH_MUL);
				end
				expr_syms.push_back(CH_0 + 8'd2);
				expr_syms.push_back(CH_MUL);
				expr_syms.push_back(CH_0);
				expr_syms.push_back(CH_0 + 8'd1);
				expr_syms.push_back(CH_MINUS);
				expr_syms.push_back(CH_DIV);
				case ($urandom_range(3))
					1: begin
						expr_syms.push_back(CH_0 + 8'd1);
						expr_syms.push_back(CH_MINUS);
					end
					2: begin
						expr_syms.push_back(CH_0);
						expr_syms.push_back(CH_0 + 8'd1);
						expr_syms.push_back(CH_MINUS);
						expr_syms.push_back(CH_MUL);
					end
					3: begin
						expr_syms.push_back(CH_0 + 8'd9);
						expr_syms.push_back(CH_MUL);
					end
					default: ;
				endcase
			end
			default: expr_syms.push_back($urandom_range(1) ? random_digit() : random_op());
		endcase
		foreach (expr_syms[i]) begin
			e        = '0;
			e.symbol = expr_syms[i];
			e.last   = (i == expr_syms.size() - 1);
			symbol_stream.push_back(e);
		end
		expr_total++;
	endtask

	// input side: predict on every accepted symbol
	always @(posedge clk) begin : symbol_monitor
		res_t r;
		if (arst_n && sym_ch.valid && sym_ch.ready) begin
			accepted_items++;
			if (evaluate_symbol({offered.symbol, offered.last}, r)) begin
				if (offered.preset) begin
					r.value  = offered.value;
					r.status = offered.status;
				end
				pending_results.push_back(r);
			end
		end
	end

	// output side: compare against the oldest expected result
	always @(posedge clk) begin : result_check
		res_t want;
		res_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = res_ch.payload;
			results_seen++;
			if (got.status <= STAT_BAD)
				status_count[got.status]++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_MAX)
					$display("unexpected result: value %0d status %0d", got.value, got.status);
			end else begin
				want = pending_results.pop_front();
				if (got.value !== want.value || got.status !== want.status) begin
					mismatches++;
					if (mismatches <= SHOW_MAX)
						$display("result %0d: value exp %0d got %0d, status exp %0d got %0d",
							results_seen, want.value, got.value, want.status, got.status);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((sym_ch.valid && sym_ch.ready) || (res_ch.valid && res_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: %0d cycles without a handshake, %0d results outstanding",
					stall_cycles, pending_results.size());
				$display("tb: failure");
				$finish;
			end
		end
	end

	// result receiver: random stalls, one long hold-off once the run is going
	initial begin : receiver
		int  hold_left;
		bit  hold_done;
		hold_left    = 0;
		hold_done    = 1'b0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && accepted_items >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				res_ch.ready = 1'b0;
				hold_left--;
			end else if (quiet)
				res_ch.ready = 1'b1;
			else
				res_ch.ready = ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// stimulus build, reset, symbol sender and end of run
	initial begin : main_seq
		int counted;
		int n;
		int pick;
		expr_kind_e kind;

		arst_n         = 1'b0;
		sym_ch.valid   = 1'b0;
		sym_ch.payload = '0;
		offered        = '0;
		quiet          = 1'b0;
		stack_fill     = 0;
		stack_err      = STAT_OK;
		accepted_items = 0;
		results_seen   = 0;
		mismatches     = 0;
		stall_cycles   = 0;
		expr_total     = 0;
		foreach (status_count[i])
			status_count[i] = 0;

		foreach (directed_rows[i]) begin
			symbol_stream.push_back(directed_rows[i]);
			if (directed_rows[i].last)
				expr_total++;
		end

		// random part: every kind once, then weighted picks
		counted = 0;
		n       = 0;
		while (counted < ITEMS) begin
			if (n < EXPR_KINDS)
				kind = expr_kind_e'(n);
			else begin
				pick = $urandom_range(99);
				kind = (pick < 58) ? EXPR_CLEAN :
					(pick < 68) ? EXPR_BROKEN :
					(pick < 76) ? EXPR_NOISE :
					(pick < 82) ? EXPR_FILL :
					(pick < 88) ? EXPR_MINDIV : EXPR_SINGLE;
			end
			add_random_expression(kind);
			counted += expr_syms.size();
			n++;
		end

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// send every symbol, valid stays up across back-to-back items
		foreach (symbol_stream[i]) begin
			quiet = (i >= QUIET_FROM && i < QUIET_TO);
			while (!quiet && $urandom_range(99) < IDLE_PCT) begin
				sym_ch.valid = 1'b0;
				@(negedge clk);
			end
			offered        = symbol_stream[i];
			sym_ch.payload = {offered.symbol, offered.last};
			sym_ch.valid   = 1'b1;
			do @(posedge clk); while (!sym_ch.ready);
			@(negedge clk);
		end
		sym_ch.valid = 1'b0;
		quiet        = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_results.size() != 0) begin
			$display("%0d expected results never arrived", pending_results.size());
			mismatches += pending_results.size();
		end
		$display("summary: %0d symbols in %0d expressions, %0d results checked, %0d mismatches",
			accepted_items, expr_total, results_seen, mismatches);
		$display("summary: status ok %0d, underflow %0d, overflow %0d, div by zero %0d, bad %0d",
			status_count[STAT_OK], status_count[STAT_UNDER], status_count[STAT_OVER],
			status_count[STAT_DIVZ], status_count[STAT_BAD]);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
